@@ sv/fba_pkg.sv @@
`default_nettype none
package fba_pkg;
    localparam int RECORDS_DEF = 32;
    localparam int MAX_BLOCKS_DEF = 16;
    localparam int BLOCK_SPACE_DEF = 256;
    localparam logic [7:0] DATA_BLOCKS_RST = 8'd255;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_BAD_STATE = 2'd2,
        ST_BAD_COUNT = 2'd3
    } t_status;

    typedef enum logic {
        MODE_ALLOC   = 1'b0,
        MODE_RELEASE = 1'b1
    } t_mode;
endpackage
`default_nettype wire

@@ sv/fba_ram.sv @@
`default_nettype none
module fba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ sv/flash_block_allocator_top.sv @@
// An allocation runs an ownership scan, then a free count scan, one bit per cycle each; a replace
// also reads reused list entries first and frees the old ones after the scan, and each picked
// block is written. A release frees its list entries, then runs the count scan; a bad count or
// wrong state item runs only the count scan. Results go out one per cycle while o_valid and
// i_ready are high. One item at a time, next item accepted after the last result of the item.
// Reset (synchronous, active low) clears record state and zeroes ownership; no item taken.
`default_nettype none
module flash_block_allocator_top #(
    parameter int RECORDS               = fba_pkg::RECORDS_DEF,
    parameter int MAX_BLOCKS_PER_RECORD = fba_pkg::MAX_BLOCKS_DEF,
    parameter int BLOCK_SPACE           = fba_pkg::BLOCK_SPACE_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic       i_mode,
    input  wire logic [4:0] i_record_index,
    input  wire logic       i_replace,
    input  wire logic [4:0] i_block_need,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_block_number,
    output logic            o_last,
    output logic [1:0]      o_status,
    output logic [7:0]      o_free_blocks
);
    import fba_pkg::*;

    localparam int BW = $clog2(BLOCK_SPACE);
    localparam int RW = (RECORDS > 1) ? $clog2(RECORDS) : 1;
    localparam int IW = (MAX_BLOCKS_PER_RECORD > 1) ? $clog2(MAX_BLOCKS_PER_RECORD) : 1;
    localparam int CW = $clog2(MAX_BLOCKS_PER_RECORD + 1);
    localparam int LAW = RW + IW;
    localparam int LDEPTH = RECORDS << IW;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_PRE_RD, S_PRE_WR, S_SCAN, S_DROP_RD, S_DROP_WR,
        S_WRITE, S_COUNT, S_EMIT
    } t_state;

    t_state              r_state;
    logic [BW-1:0]       r_clr;
    logic [7:0]          r_data_blocks;
    logic [RECORDS-1:0]  r_rec_valid;
    logic [CW-1:0]       r_rec_total [RECORDS];
    logic [7:0]          r_pick [MAX_BLOCKS_PER_RECORD];
    logic [RW-1:0]       r_rec;
    logic [CW-1:0]       r_need;
    logic [CW-1:0]       r_tot;
    logic [CW-1:0]       r_i;
    logic [CW-1:0]       r_n;
    logic [IW-1:0]       r_k;
    logic                r_repl;
    logic                r_rel;
    logic                r_single;
    t_status             r_st;
    logic [BW:0]         r_b;
    logic                r_pend;
    logic [BW-1:0]       r_paddr;
    logic [7:0]          r_cnt;

    logic                own_we;
    logic [BW-1:0]       own_waddr;
    logic                own_wdata;
    logic                own_rdata;
    logic                list_we;
    logic [LAW-1:0]      list_addr;
    logic [7:0]          list_wdata;
    logic [7:0]          list_rdata;
    logic [BW:0]         top;
    logic                issue;
    logic                scan_done;
    logic [RW-1:0]       in_rec;
    logic                in_rec_ok;
    logic                in_valid_rec;

    fba_ram #(.WIDTH(1), .DEPTH(BLOCK_SPACE), .AW(BW)) u_own (
        .i_clk   (i_clk),
        .i_we    (own_we),
        .i_waddr (own_waddr),
        .i_wdata (own_wdata),
        .i_raddr (r_b[BW-1:0]),
        .o_rdata (own_rdata)
    );

    fba_ram #(.WIDTH(8), .DEPTH(LDEPTH), .AW(LAW)) u_list (
        .i_clk   (i_clk),
        .i_we    (list_we),
        .i_waddr (list_addr),
        .i_wdata (list_wdata),
        .i_raddr (list_addr),
        .o_rdata (list_rdata)
    );

    assign top = (32'(r_data_blocks) > BLOCK_SPACE - 1) ? (BW+1)'(BLOCK_SPACE - 1)
                                                        : (BW+1)'(r_data_blocks);
    assign issue = ((r_state == S_SCAN) || (r_state == S_COUNT)) && (r_b <= top);
    assign scan_done = !issue && !r_pend;
    assign in_rec = RW'(i_record_index);
    assign in_rec_ok = 32'(i_record_index) < RECORDS;
    assign in_valid_rec = in_rec_ok && r_rec_valid[in_rec];

    assign o_cfg_ready = 1'b1;
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_EMIT);
    assign o_block_number = r_single ? 8'd0 : r_pick[r_k];
    assign o_last = r_single || (CW'(r_k) + CW'(1) == r_need);
    assign o_status = r_st;
    assign o_free_blocks = r_cnt;

    always_comb begin
        own_we = 1'b0;
        own_waddr = r_clr;
        own_wdata = 1'b0;
        list_we = 1'b0;
        list_addr = {r_rec, r_i[IW-1:0]};
        list_wdata = r_pick[r_i[IW-1:0]];
        unique case (r_state)
            S_CLR: begin
                own_we = 1'b1;
            end
            S_DROP_WR: begin
                own_we = 1'b1;
                own_waddr = list_rdata[BW-1:0];
            end
            S_WRITE: begin
                if (r_i < r_need) begin
                    own_we = 1'b1;
                    own_waddr = r_pick[r_i[IW-1:0]][BW-1:0];
                    own_wdata = 1'b1;
                    list_we = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr <= '0;
            r_data_blocks <= DATA_BLOCKS_RST;
            r_rec_valid <= '0;
            for (int j = 0; j < RECORDS; j++) begin
                r_rec_total[j] <= '0;
            end
            r_pend <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_data_blocks <= i_cfg_data;
            end
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + BW'(1);
                    if (r_clr == BW'(BLOCK_SPACE - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_rec <= in_rec;
                        r_need <= CW'(i_block_need);
                        r_tot <= r_rec_total[in_rec];
                        r_repl <= i_replace;
                        r_i <= '0;
                        r_n <= '0;
                        r_k <= '0;
                        r_b <= (BW+1)'(1);
                        r_pend <= 1'b0;
                        r_cnt <= '0;
                        r_single <= 1'b1;
                        r_rel <= 1'b0;
                        r_st <= ST_OK;
                        if (i_mode == MODE_RELEASE) begin
                            if (!in_valid_rec) begin
                                r_st <= ST_BAD_STATE;
                                r_state <= S_COUNT;
                            end else begin
                                r_rel <= 1'b1;
                                r_state <= S_DROP_RD;
                            end
                        end else if (i_block_need == 5'd0
                                     || 32'(i_block_need) > MAX_BLOCKS_PER_RECORD) begin
                            r_st <= ST_BAD_COUNT;
                            r_state <= S_COUNT;
                        end else if (!in_rec_ok || (i_replace ? !in_valid_rec : in_valid_rec))
                        begin
                            r_st <= ST_BAD_STATE;
                            r_state <= S_COUNT;
                        end else begin
                            r_single <= 1'b0;
                            r_state <= i_replace ? S_PRE_RD : S_SCAN;
                        end
                    end
                end
                S_PRE_RD: begin
                    if (r_i < r_tot && r_i < r_need) begin
                        r_state <= S_PRE_WR;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_PRE_WR: begin
                    r_pick[r_n[IW-1:0]] <= list_rdata;
                    r_n <= r_n + CW'(1);
                    r_i <= r_i + CW'(1);
                    r_state <= S_PRE_RD;
                end
                S_SCAN, S_COUNT: begin
                    if (issue) begin
                        r_b <= r_b + (BW+1)'(1);
                    end
                    r_pend <= issue;
                    r_paddr <= r_b[BW-1:0];
                    if (r_pend && !own_rdata) begin
                        if (r_state == S_COUNT) begin
                            r_cnt <= r_cnt + 8'd1;
                        end else if (r_n < r_need) begin
                            r_pick[r_n[IW-1:0]] <= 8'(r_paddr);
                            r_n <= r_n + CW'(1);
                        end
                    end
                    if (scan_done) begin
                        r_i <= '0;
                        r_b <= (BW+1)'(1);
                        if (r_state == S_COUNT) begin
                            r_state <= S_EMIT;
                        end else if (r_n < r_need) begin
                            r_st <= ST_NO_SPACE;
                            r_single <= 1'b1;
                            r_state <= S_COUNT;
                        end else begin
                            r_state <= r_repl ? S_DROP_RD : S_WRITE;
                        end
                    end
                end
                S_DROP_RD: begin
                    if (r_i < r_tot) begin
                        r_state <= S_DROP_WR;
                    end else if (r_rel) begin
                        r_rec_valid[r_rec] <= 1'b0;
                        r_rec_total[r_rec] <= '0;
                        r_state <= S_COUNT;
                    end else begin
                        r_i <= '0;
                        r_state <= S_WRITE;
                    end
                end
                S_DROP_WR: begin
                    r_i <= r_i + CW'(1);
                    r_state <= S_DROP_RD;
                end
                S_WRITE: begin
                    if (r_i < r_need) begin
                        r_i <= r_i + CW'(1);
                    end else begin
                        r_rec_valid[r_rec] <= 1'b1;
                        r_rec_total[r_rec] <= r_need;
                        r_state <= S_COUNT;
                    end
                end
                S_EMIT: begin
                    if (i_ready) begin
                        if (o_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k <= r_k + IW'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

@@ sv/fba_checker.sv @@
`default_nettype none
module fba_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_ready,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [7:0] o_block_number,
    input wire logic       o_last,
    input wire logic [1:0] o_status,
    input wire logic [7:0] o_free_blocks
);
    import fba_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_block_number) && $stable(o_last)
            && $stable(o_status) && $stable(o_free_blocks))
        else $error("result changed while stalled");

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_last && o_block_number == 8'd0)
        else $error("error item not a single empty result");

    a_mid_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_status == ST_OK && o_block_number != 8'd0)
        else $error("non-final result without a block");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input taken while results pending");
endmodule

bind flash_block_allocator_top fba_checker u_fba_checker (.*);
`default_nettype wire

@@ tb/flash_block_allocator_top_test.sv @@
`timescale 1ns / 100ps
`default_nettype none
module flash_block_allocator_top_test;
    import fba_pkg::*;

    localparam int NREC = 32;
    localparam int MAXB = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [7:0] blk;
        logic       last;
        logic [1:0] status;
        logic [7:0] free;
    } t_alloc_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic [7:0] i_cfg_data = '0;
    logic       i_valid = 1'b0;
    logic       i_mode = 1'b0;
    logic [4:0] i_record_index = '0;
    logic       i_replace = 1'b0;
    logic [4:0] i_block_need = '0;
    logic       i_ready = 1'b0;
    logic       o_cfg_ready, o_ready, o_valid, o_last;
    logic [7:0] o_block_number, o_free_blocks;
    logic [1:0] o_status;

    flash_block_allocator_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready), .i_mode(i_mode),
        .i_record_index(i_record_index), .i_replace(i_replace),
        .i_block_need(i_block_need),
        .o_valid(o_valid), .i_ready(i_ready), .o_block_number(o_block_number),
        .o_last(o_last), .o_status(o_status), .o_free_blocks(o_free_blocks)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // allocator shadow state
    logic [7:0]    shadow_limit;
    logic          shadow_owned [256];
    logic          shadow_valid [NREC];
    int unsigned   shadow_total [NREC];
    logic [7:0]    shadow_list [NREC][MAXB];
    t_alloc_result pending_results[$];

    int  mismatches = 0;
    int  results_seen = 0;
    int  items_sent = 0;
    int  idle_pct = 34;
    int  quiet_cycles = 0;
    int  ok_allocs = 0;

    function automatic logic [7:0] count_unowned();
        int n;
        n = 0;
        for (int b = 1; b <= shadow_limit; b++)
            if (!shadow_owned[b]) n++;
        return n[7:0];
    endfunction

    function automatic void push_single(t_status st);
        t_alloc_result r;
        r.blk = 8'd0;
        r.last = 1'b1;
        r.status = st;
        r.free = count_unowned();
        pending_results.push_back(r);
    endfunction

    function automatic void predict_item(t_mode mode, int rec, bit repl, int need);
        logic [7:0] pick [MAXB];
        int n;
        t_alloc_result r;
        n = 0;
        if (mode == MODE_RELEASE) begin
            if (!shadow_valid[rec]) begin
                push_single(ST_BAD_STATE);
                return;
            end
            for (int i = 0; i < shadow_total[rec]; i++)
                shadow_owned[shadow_list[rec][i]] = 1'b0;
            shadow_valid[rec] = 1'b0;
            shadow_total[rec] = 0;
            push_single(ST_OK);
            return;
        end
        if (need == 0 || need > MAXB) begin
            push_single(ST_BAD_COUNT);
            return;
        end
        if (repl ? !shadow_valid[rec] : shadow_valid[rec]) begin
            push_single(ST_BAD_STATE);
            return;
        end
        if (repl)
            for (int i = 0; i < shadow_total[rec] && n < need; i++)
                pick[n++] = shadow_list[rec][i];
        for (int b = 1; b <= shadow_limit && n < need; b++)
            if (!shadow_owned[b]) pick[n++] = b[7:0];
        if (n < need) begin
            push_single(ST_NO_SPACE);
            return;
        end
        if (repl)
            for (int i = 0; i < shadow_total[rec]; i++)
                shadow_owned[shadow_list[rec][i]] = 1'b0;
        for (int i = 0; i < need; i++) begin
            shadow_list[rec][i] = pick[i];
            shadow_owned[pick[i]] = 1'b1;
        end
        shadow_valid[rec] = 1'b1;
        shadow_total[rec] = need;
        ok_allocs++;
        for (int i = 0; i < need; i++) begin
            r.blk = pick[i];
            r.last = (i == need - 1);
            r.status = ST_OK;
            r.free = count_unowned();
            pending_results.push_back(r);
        end
    endfunction

    // result checker and output stall
    always @(posedge i_clk) begin
        t_alloc_result want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result blk=%0d last=%0d st=%0d free=%0d",
                             o_block_number, o_last, o_status, o_free_blocks);
            end else begin
                want = pending_results.pop_front();
                if (o_block_number !== want.blk || o_last !== want.last ||
                    o_status !== want.status || o_free_blocks !== want.free) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp blk=%0d last=%0d st=%0d free=%0d, got %0d %0d %0d %0d",
                                 want.blk, want.last, want.status, want.free,
                                 o_block_number, o_last, o_status, o_free_blocks);
                end
            end
        end
        i_ready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)
            || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress");
            $display("flash_block_allocator_top regression: fail");
            $finish;
        end
    end

    task automatic send_item(t_mode mode, int rec, bit repl, int need);
        while ($urandom_range(99) < idle_pct) @(posedge i_clk);
        i_valid <= 1'b1;
        i_mode <= mode;
        i_record_index <= rec[4:0];
        i_replace <= repl;
        i_block_need <= need[4:0];
        do @(posedge i_clk); while (!o_ready);
        predict_item(mode, rec, repl, need);
        items_sent++;
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (700) @(posedge i_clk);
    endtask

    task automatic write_limit(int value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value[7:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        shadow_limit = value[7:0];
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        send_item(MODE_ALLOC, 0, 0, 0);
        send_item(MODE_ALLOC, 0, 0, 17);
        send_item(MODE_ALLOC, 0, 0, 31);
        send_item(MODE_RELEASE, 0, 0, 0);
        send_item(MODE_ALLOC, 3, 1, 4);
        send_item(MODE_ALLOC, 0, 0, 1);
        send_item(MODE_ALLOC, 31, 0, 16);
        send_item(MODE_ALLOC, 31, 0, 2);
        send_item(MODE_ALLOC, 31, 1, 5);
        send_item(MODE_ALLOC, 31, 1, 16);
        send_item(MODE_RELEASE, 0, 1, 31);
        send_item(MODE_RELEASE, 0, 0, 3);
        send_item(MODE_ALLOC, 5, 0, 16);
    endtask

    task automatic test_small_space();
        write_limit(0);
        send_item(MODE_ALLOC, 7, 0, 1);
        send_item(MODE_ALLOC, 5, 1, 16);
        send_item(MODE_ALLOC, 5, 1, 3);
        write_limit(1);
        send_item(MODE_ALLOC, 8, 0, 1);
        send_item(MODE_ALLOC, 9, 0, 1);
        write_limit(20);
        send_item(MODE_ALLOC, 5, 1, 10);
        send_item(MODE_ALLOC, 9, 0, 16);
        send_item(MODE_RELEASE, 8, 0, 0);
    endtask

    task automatic random_items(int count, bit quiet);
        int sel, rec, need;
        for (int k = 0; k < count; k++) begin
            idle_pct = quiet ? 0 : 34;
            sel = $urandom_range(99);
            rec = $urandom_range(31);
            need = (sel < 5) ? $urandom_range(31) : $urandom_range(16, 1);
            if (sel < 45)
                send_item(MODE_ALLOC, rec, shadow_valid[rec], need);
            else if (sel < 75)
                send_item(MODE_RELEASE, rec, $urandom_range(1), $urandom_range(31));
            else
                send_item(t_mode'($urandom_range(1)), rec, $urandom_range(1), need);
        end
        idle_pct = 34;
    endtask

    initial begin
        shadow_limit = DATA_BLOCKS_RST;
        foreach (shadow_owned[b]) shadow_owned[b] = 1'b0;
        foreach (shadow_valid[r]) begin
            shadow_valid[r] = 1'b0;
            shadow_total[r] = 0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_small_space();
        write_limit(255);
        random_items(80, 0);
        drain();
        random_items(40, 1);
        write_limit(60);
        random_items(70, 0);
        write_limit(255);
        random_items(40, 0);
        drain();
        $display("covered %0d items, %0d results, %0d good allocations, limits 0/1/20/60/255",
                 items_sent, results_seen, ok_allocs);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("flash_block_allocator_top regression: pass");
        else
            $display("flash_block_allocator_top regression: fail");
        $finish;
    end
endmodule
`default_nettype wire
